// ===== rtl/lgm_pkg.sv =====
package lgm_pkg;

  // column and row indexes, wide enough for the largest grid side
  localparam int IDX_W = 12;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = 3;
  localparam int QCNT_W = 4;

  localparam logic [2:0] REG_LOCAL_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_LOCAL_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_LOCAL_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_POSE_X          = 3'd3;
  localparam logic [2:0] REG_POSE_Y          = 3'd4;
  localparam logic [2:0] REG_COS_YAW         = 3'd5;
  localparam logic [2:0] REG_SIN_YAW         = 3'd6;
  localparam logic [2:0] REG_CELLS_PER_METRE = 3'd7;

  localparam logic [20:0] RST_LOCAL_CELL_SIZE = 21'd6554;
  localparam logic [15:0] RST_COS_YAW         = 16'd16384;
  localparam logic [15:0] RST_CELLS_PER_METRE = 16'd2560;

  localparam logic signed [7:0] UNKNOWN = -8'sd1;

  typedef struct packed {
    logic signed [31:0] local_origin_x;
    logic signed [31:0] local_origin_y;
    logic [20:0]        local_cell_size;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic [15:0]        cells_per_metre;
  } cfg_t;

  typedef struct packed {
    logic               merge;
    logic               in_bounds;
    logic [IDX_W-1:0]   gx;
    logic [IDX_W-1:0]   gy;
    logic signed [7:0]  value;
  } qent_t;

endpackage

// ===== rtl/lgm_queue.sv =====
module lgm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lgm_pkg::qent_t push_data,
  input  logic           pop,
  output lgm_pkg::qent_t pop_data,
  output logic           empty
);

  lgm_pkg::qent_t                   q [lgm_pkg::QDEPTH];
  logic [lgm_pkg::QPTR_W-1:0]       wr_ptr;
  logic [lgm_pkg::QPTR_W-1:0]       rd_ptr;
  logic [lgm_pkg::QCNT_W-1:0]       count;

  assign empty    = (count == '0);
  assign pop_data = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + lgm_pkg::QCNT_W'(push) - lgm_pkg::QCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/lgm_front.sv =====
module lgm_front #(
  parameter int GLOBAL_WIDTH   = 256,
  parameter int GLOBAL_HEIGHT  = 256,
  parameter int LOCAL_MAX_SIDE = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  lgm_pkg::cfg_t     cfg,
  input  logic              clearing,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [7:0]        cell_x,
  input  logic [7:0]        cell_y,
  input  logic signed [7:0] cell_value,
  input  logic [7:0]        read_x,
  input  logic [7:0]        read_y,
  input  logic              q_pop,
  output logic              q_push,
  output lgm_pkg::qent_t    q_data
);

  localparam int IW = lgm_pkg::IDX_W;

  typedef struct packed {
    logic              mode;
    logic              local_ok;
    logic signed [7:0] value;
    logic [7:0]        rx;
    logic [7:0]        ry;
  } meta_t;

  logic                        accept;
  logic [lgm_pkg::QCNT_W-1:0]  pend;

  // stage 1: local centre, Q16.17
  logic                v1;
  meta_t               m1;
  logic signed [33:0]  lx;
  logic signed [33:0]  ly;
  logic [29:0]         px;
  logic [29:0]         py;

  // stage 2: rotation products
  logic                v2;
  meta_t               m2;
  logic signed [49:0]  lxc;
  logic signed [49:0]  lys;
  logic signed [49:0]  lxs;
  logic signed [49:0]  lyc;

  // stage 3: world position, Q16.16 rounded down
  logic                v3;
  meta_t               m3;
  logic signed [51:0]  wx_full;
  logic signed [51:0]  wy_full;
  logic signed [36:0]  wx;
  logic signed [36:0]  wy;

  // stage 4: scaled, Q.24
  logic                v4;
  meta_t               m4;
  logic signed [53:0]  sx;
  logic signed [53:0]  sy;

  logic signed [29:0]  qx;
  logic signed [29:0]  qy;
  logic                proj_in;
  logic                read_in;
  logic                inb;

  assign accept   = in_valid && !in_stall;
  assign in_stall = clearing || (pend == lgm_pkg::QCNT_W'(lgm_pkg::QDEPTH));

  assign px = 30'({cell_x, 1'b1}) * 30'(cfg.local_cell_size);
  assign py = 30'({cell_y, 1'b1}) * 30'(cfg.local_cell_size);

  assign wx_full = 52'($signed({cfg.pose_x, 15'b0})) + 52'(lxc) - 52'(lys);
  assign wy_full = 52'($signed({cfg.pose_y, 15'b0})) + 52'(lxs) + 52'(lyc);

  // truncate toward zero
  assign qx = $signed(sx[53:24]) + $signed({29'b0, sx[53] && (sx[23:0] != '0)});
  assign qy = $signed(sy[53:24]) + $signed({29'b0, sy[53] && (sy[23:0] != '0)});

  assign proj_in = m4.local_ok && !qx[29] && !qy[29] &&
                   (qx[28:0] < 29'(GLOBAL_WIDTH)) && (qy[28:0] < 29'(GLOBAL_HEIGHT));
  assign read_in = ({5'b0, m4.rx} < 13'(GLOBAL_WIDTH)) &&
                   ({5'b0, m4.ry} < 13'(GLOBAL_HEIGHT));
  assign inb     = m4.mode ? read_in : proj_in;

  always_comb begin
    q_data.merge     = !m4.mode && !m4.value[7];
    q_data.in_bounds = inb;
    q_data.value     = m4.value;
    q_data.gx        = '0;
    q_data.gy        = '0;
    if (inb) begin
      q_data.gx = m4.mode ? IW'(m4.rx) : qx[IW-1:0];
      q_data.gy = m4.mode ? IW'(m4.ry) : qy[IW-1:0];
    end
  end

  assign q_push = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
    end else begin
      pend <= pend + lgm_pkg::QCNT_W'(accept) - lgm_pkg::QCNT_W'(q_pop);
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
    end
  end

  always_ff @(posedge clk) begin
    m1.mode     <= mode;
    m1.local_ok <= ({5'b0, cell_x} < 13'(LOCAL_MAX_SIDE)) &&
                   ({5'b0, cell_y} < 13'(LOCAL_MAX_SIDE));
    m1.value    <= cell_value;
    m1.rx       <= read_x;
    m1.ry       <= read_y;
    lx <= $signed({cfg.local_origin_x[31], cfg.local_origin_x, 1'b0}) + $signed({4'b0, px});
    ly <= $signed({cfg.local_origin_y[31], cfg.local_origin_y, 1'b0}) + $signed({4'b0, py});

    m2  <= m1;
    lxc <= 50'(lx) * 50'(cfg.cos_yaw);
    lys <= 50'(ly) * 50'(cfg.sin_yaw);
    lxs <= 50'(lx) * 50'(cfg.sin_yaw);
    lyc <= 50'(ly) * 50'(cfg.cos_yaw);

    m3 <= m2;
    wx <= wx_full[51:15];
    wy <= wy_full[51:15];

    m4 <= m3;
    sx <= 54'(wx) * 54'($signed({1'b0, cfg.cells_per_metre}));
    sy <= 54'(wy) * 54'($signed({1'b0, cfg.cells_per_metre}));
  end

endmodule

// ===== rtl/lgm_back.sv =====
module lgm_back #(
  parameter int GLOBAL_WIDTH  = 256,
  parameter int GLOBAL_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst,
  output logic              clearing,
  input  logic              q_empty,
  input  lgm_pkg::qent_t    q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              in_bounds,
  output logic [7:0]        global_x,
  output logic [7:0]        global_y,
  output logic              updated,
  output logic signed [7:0] stored_value
);

  localparam int XW    = $clog2(GLOBAL_WIDTH);
  localparam int YW    = $clog2(GLOBAL_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WRITE
  } state_t;

  state_t             state;
  lgm_pkg::qent_t     cur;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      wr_addr;
  logic signed [7:0]  wr_data;
  logic               wr_en;
  logic signed [7:0]  rd_data;
  logic               out_free;
  logic               raise;
  logic signed [7:0]  mem [DEPTH];

  assign addr     = {cur.gy[YW-1:0], cur.gx[XW-1:0]};
  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;
  assign raise    = cur.in_bounds && cur.merge && (cur.value > rd_data);
  assign wr_en    = clearing || ((state == S_WRITE) && out_free && raise);
  assign wr_addr  = clearing ? clr_addr : addr;
  assign wr_data  = clearing ? lgm_pkg::UNKNOWN : cur.value;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ((state == S_WRITE) && out_free) || (out_valid && out_stall);
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cur   <= q_data;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            in_bounds    <= cur.in_bounds;
            global_x     <= cur.gx[7:0];
            global_y     <= cur.gy[7:0];
            updated      <= raise;
            stored_value <= !cur.in_bounds ? 8'sd0 : (raise ? cur.value : rd_data);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/local_grid_to_global_max_merge_top.sv =====
// Path: out_valid rises after the input transfer when the back end is free, the item passing
// through the 4 transform stages, queue write, pop, grid read and result register.
// The back end takes a new item only after the grid memory read-modify-write of the last one;
// the transform pipeline takes one item per cycle unless 8 items are pending or the grid is clearing.
// Reset (rst, synchronous): clears control and loads register defaults, then sweeps the
// grid to -1 one cell per cycle over every cell (each side pow2-rounded), in_stall high.
module local_grid_to_global_max_merge_top #(
  parameter int GLOBAL_WIDTH   = 256,
  parameter int GLOBAL_HEIGHT  = 256,
  parameter int LOCAL_MAX_SIDE = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [7:0]        cell_x,
  input  logic [7:0]        cell_y,
  input  logic signed [7:0] cell_value,
  input  logic [7:0]        read_x,
  input  logic [7:0]        read_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              in_bounds,
  output logic [7:0]        global_x,
  output logic [7:0]        global_y,
  output logic              updated,
  output logic signed [7:0] stored_value
);

  lgm_pkg::cfg_t  cfg;
  logic           clearing;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  lgm_pkg::qent_t q_wdata;
  lgm_pkg::qent_t q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_origin_x  <= '0;
      cfg.local_origin_y  <= '0;
      cfg.local_cell_size <= lgm_pkg::RST_LOCAL_CELL_SIZE;
      cfg.pose_x          <= '0;
      cfg.pose_y          <= '0;
      cfg.cos_yaw         <= lgm_pkg::RST_COS_YAW;
      cfg.sin_yaw         <= '0;
      cfg.cells_per_metre <= lgm_pkg::RST_CELLS_PER_METRE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lgm_pkg::REG_LOCAL_ORIGIN_X:  cfg.local_origin_x  <= cfg_data;
        lgm_pkg::REG_LOCAL_ORIGIN_Y:  cfg.local_origin_y  <= cfg_data;
        lgm_pkg::REG_LOCAL_CELL_SIZE: cfg.local_cell_size <= cfg_data[20:0];
        lgm_pkg::REG_POSE_X:          cfg.pose_x          <= cfg_data;
        lgm_pkg::REG_POSE_Y:          cfg.pose_y          <= cfg_data;
        lgm_pkg::REG_COS_YAW:         cfg.cos_yaw         <= cfg_data[15:0];
        lgm_pkg::REG_SIN_YAW:         cfg.sin_yaw         <= cfg_data[15:0];
        lgm_pkg::REG_CELLS_PER_METRE: cfg.cells_per_metre <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lgm_front #(
    .GLOBAL_WIDTH   (GLOBAL_WIDTH),
    .GLOBAL_HEIGHT  (GLOBAL_HEIGHT),
    .LOCAL_MAX_SIDE (LOCAL_MAX_SIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clearing   (clearing),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_value (cell_value),
    .read_x     (read_x),
    .read_y     (read_y),
    .q_pop      (q_pop),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  lgm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  lgm_back #(
    .GLOBAL_WIDTH  (GLOBAL_WIDTH),
    .GLOBAL_HEIGHT (GLOBAL_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .in_bounds    (in_bounds),
    .global_x     (global_x),
    .global_y     (global_y),
    .updated      (updated),
    .stored_value (stored_value)
  );

endmodule
